>>> rtl/core/rast_pkg.sv
// Shared types and constants for the range-add range-sum tree block.
package rast_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned RST_COUNT = 1024;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PRE_RD,
    S_PRE_ACC,
    S_PRE_MUL,
    S_PRE_END,
    S_UPD_MUL,
    S_UPD_SET,
    S_UPD_RD,
    S_UPD_WR,
    S_DONE
  } state_e;

endpackage

>>> rtl/core/rast_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rast_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rast_mul.sv
// Shared registered multiplier: 64-bit value times a narrow position, wrapped to 64 bits.
module rast_mul import rast_pkg::*; #(
  parameter int unsigned BW = 11
) (
  input  logic              clk_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [BW-1:0]     b_i,
  output logic [DATA_W-1:0] p_o
);

  logic [DATA_W+BW-1:0] full;
  logic [DATA_W-1:0]    p_q;

  assign full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= full[DATA_W-1:0];
  end

  assign p_o = p_q;

endmodule

>>> rtl/core/range_add_range_sum_tree_top.sv
// Channel   | direction | handshake            | payload
// input     | in        | in_valid_i/in_stall_o | func_i, first_index_i, last_index_i, operand_value_i
// result    | out       | out_valid_o/out_stall_i | range_sum_o
// config    | in        | cfg_we_i             | cfg_wdata_i (element count)
// The array is held as two Fenwick trees packed in one RAM word; a sequencer walks them.
// Each tree step goes through the one RAM, at most log2(MAX_ELEMENTS)+1
// steps per walk: a query takes two walks, an add two, a load four.
// After reset and after each count write a clear pass over every RAM word runs first.
// A result waits in an output register; the next item is taken once the sequencer is idle.
module range_add_range_sum_tree_top import rast_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [IDX_W-1:0]  first_index_i,
  input  logic [IDX_W-1:0]  last_index_i,
  input  logic [DATA_W-1:0] operand_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] range_sum_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned PW = IW + 1;
  localparam int unsigned RW = 2 * DATA_W;
  localparam int unsigned RST_N = (RST_COUNT > MAX_ELEMENTS) ? MAX_ELEMENTS : RST_COUNT;

  state_e            state_q, state_d;
  logic [IW-1:0]     n_q, n_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic [IW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic              phase_q, phase_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [DATA_W-1:0] acc1_q, acc1_d, acc2_q, acc2_d;
  logic [DATA_W-1:0] p1_q, p1_d, delta_q, delta_d;
  logic [DATA_W-1:0] d1_q, d1_d, d2_q, d2_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_sum_q, out_sum_d;

  logic [PW-1:0]     lowbit, pos_m1;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [RW-1:0]     ram_wdata, ram_rdata;
  logic [DATA_W-1:0] mul_a, mul_p, pre_sum, diff;
  logic [IW-1:0]     mul_b;
  logic [31:0]       a32, b32, n32, bc32, cfg32;

  rast_ram #(.WIDTH(RW), .DEPTH(MAX_ELEMENTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(pos_m1[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  rast_mul #(.BW(IW)) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  assign lowbit = pos_q & (~pos_q + PW'(1));
  assign pos_m1 = pos_q - PW'(1);

  // Prefix walks scale the first tree by the end position; update walks scale the delta.
  assign mul_a = (state_q == S_PRE_MUL) ? acc1_q : delta_q;
  assign mul_b = (phase_q ^ (state_q == S_UPD_MUL)) ? (lo_q - IW'(1)) : hi_q;

  assign pre_sum = mul_p - acc2_q;
  assign diff    = p1_q - pre_sum;

  assign a32   = 32'(first_index_i);
  assign b32   = 32'(last_index_i);
  assign n32   = 32'(n_q);
  assign bc32  = (b32 > n32 - 32'd1) ? (n32 - 32'd1) : b32;
  assign cfg32 = 32'(cfg_wdata_i);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_sum_q;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    func_d      = func_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    val_d       = val_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    acc1_d      = acc1_q;
    acc2_d      = acc2_q;
    p1_d        = p1_q;
    delta_d     = delta_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    res_d       = res_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_m1[AW-1:0];
    ram_wdata   = {ram_rdata[RW-1:DATA_W] + d2_q, ram_rdata[DATA_W-1:0] + d1_q};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(MAX_ELEMENTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_i;
          val_d   = operand_value_i;
          phase_d = 1'b0;
          acc1_d  = '0;
          acc2_d  = '0;
          res_d   = '0;
          lo_d    = IW'(a32 + 32'd1);
          state_d = S_DONE;
          unique case (func_i)
            FUNC_LOAD: begin
              hi_d = IW'(a32 + 32'd1);
              if (a32 < n32) begin
                pos_d   = PW'(a32 + 32'd1);
                state_d = S_PRE_RD;
              end
            end
            FUNC_ADD, FUNC_QUERY: begin
              hi_d = IW'(bc32 + 32'd1);
              if (a32 <= b32 && a32 < n32) begin
                if (func_i == FUNC_ADD) begin
                  delta_d = operand_value_i;
                  pos_d   = PW'(a32 + 32'd1);
                  state_d = S_UPD_MUL;
                end else begin
                  pos_d   = PW'(bc32 + 32'd1);
                  state_d = S_PRE_RD;
                end
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_PRE_RD: begin
        state_d = S_PRE_ACC;
      end
      S_PRE_ACC: begin
        acc1_d = acc1_q + ram_rdata[DATA_W-1:0];
        acc2_d = acc2_q + ram_rdata[RW-1:DATA_W];
        pos_d  = pos_q - lowbit;
        state_d = ((pos_q - lowbit) == '0) ? S_PRE_MUL : S_PRE_RD;
      end
      S_PRE_MUL: begin
        state_d = S_PRE_END;
      end
      S_PRE_END: begin
        if (!phase_q) begin
          // Second walk covers the prefix just before the range.
          p1_d    = pre_sum;
          phase_d = 1'b1;
          acc1_d  = '0;
          acc2_d  = '0;
          pos_d   = PW'(lo_q) - PW'(1);
          state_d = (lo_q == IW'(1)) ? S_PRE_MUL : S_PRE_RD;
        end else if (func_q == FUNC_QUERY) begin
          res_d   = diff;
          state_d = S_DONE;
        end else begin
          delta_d = val_q - diff;
          phase_d = 1'b0;
          pos_d   = PW'(lo_q);
          state_d = S_UPD_MUL;
        end
      end
      S_UPD_MUL: begin
        state_d = S_UPD_SET;
      end
      S_UPD_SET: begin
        d1_d    = phase_q ? (DATA_W'(0) - delta_q) : delta_q;
        d2_d    = phase_q ? (DATA_W'(0) - mul_p) : mul_p;
        state_d = S_UPD_RD;
      end
      S_UPD_RD: begin
        if (pos_q > PW'(MAX_ELEMENTS)) begin
          if (!phase_q) begin
            phase_d = 1'b1;
            pos_d   = PW'(hi_q) + PW'(1);
            state_d = S_UPD_MUL;
          end else begin
            res_d   = '0;
            state_d = S_DONE;
          end
        end else begin
          state_d = S_UPD_WR;
        end
      end
      S_UPD_WR: begin
        ram_we  = 1'b1;
        pos_d   = pos_q + lowbit;
        state_d = S_UPD_RD;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_sum_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A count write restarts the clear pass.
    if (cfg_we_i) begin
      if (cfg32 == 32'd0) begin
        n_d = IW'(1);
      end else if (cfg32 > 32'(MAX_ELEMENTS)) begin
        n_d = IW'(MAX_ELEMENTS);
      end else begin
        n_d = IW'(cfg32);
      end
      clr_d   = '0;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      n_q         <= IW'(RST_N);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    val_q     <= val_d;
    pos_q     <= pos_d;
    acc1_q    <= acc1_d;
    acc2_q    <= acc2_d;
    p1_q      <= p1_d;
    delta_q   <= delta_d;
    d1_q      <= d1_d;
    d2_q      <= d2_d;
    res_q     <= res_d;
    out_sum_q <= out_sum_d;
  end

endmodule

>>> verif/tb_range_add_range_sum_tree_top.sv
// Testbench for the range-add range-sum tree: directed table, random traffic, scoreboard.
module tb_range_add_range_sum_tree_top;
  import rast_pkg::*;

  localparam int unsigned MAX_EL = 1024;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 1520;

  typedef struct {
    func_e            func;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    logic [63:0]      value;
    bit               typed;
    logic [63:0]      sum;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [FUNC_W-1:0] func_i = '0;
  logic [IDX_W-1:0]  first_index_i = '0;
  logic [IDX_W-1:0]  last_index_i = '0;
  logic [DATA_W-1:0] operand_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b1;
  logic [DATA_W-1:0] range_sum_o;

  // Flat copy of the array; the tree only changes how the sums are found.
  logic [63:0]  elem_val [MAX_EL];
  int unsigned  elem_count;
  logic [63:0]  sum_fifo [$];
  int unsigned  error_cnt = 0;
  int unsigned  idle_cycles = 0;
  bit           hold_long = 1'b0;

  range_add_range_sum_tree_top #(.MAX_ELEMENTS(MAX_EL)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .func_i(func_i),
    .first_index_i(first_index_i), .last_index_i(last_index_i),
    .operand_value_i(operand_value_i), .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i), .range_sum_o(range_sum_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_array(input int unsigned count);
    for (int i = 0; i < MAX_EL; i++) elem_val[i] = '0;
    elem_count = count;
  endfunction

  function automatic logic [63:0] apply_item(input func_e f, input int unsigned a,
                                             input int unsigned b, input logic [63:0] v);
    logic [63:0] total;
    total = '0;
    if (f == FUNC_LOAD) begin
      if (a < elem_count) elem_val[a] = v;
    end else if ((f == FUNC_ADD || f == FUNC_QUERY) && a <= b && a < elem_count) begin
      if (b > elem_count - 1) b = elem_count - 1;
      for (int unsigned i = a; i <= b; i++) begin
        if (f == FUNC_ADD) elem_val[i] = elem_val[i] + v;
        else total = total + elem_val[i];
      end
    end
    return total;
  endfunction

  task automatic report_mismatch(input logic [63:0] got, input logic [63:0] want);
    $display("mismatch: range_sum %h, expected %h", got, want);
    error_cnt++;
  endtask

  task automatic send_item(input func_e f, input logic [IDX_W-1:0] a,
                           input logic [IDX_W-1:0] b, input logic [63:0] v,
                           input bit typed, input logic [63:0] typed_sum);
    int unsigned gap;
    logic [63:0] predicted;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    first_index_i <= a;
    last_index_i <= b;
    operand_value_i <= v;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    predicted = apply_item(f, a, b, v);
    sum_fifo.push_back(typed ? typed_sum : predicted);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sum_fifo.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] wdata);
    int unsigned c;
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= wdata;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    c = (wdata == 0) ? 1 : ((wdata > MAX_EL) ? MAX_EL : wdata);
    clear_array(c);
  endtask

  task automatic random_items(input int unsigned n);
    func_e f;
    int unsigned a, b, lim;
    logic [63:0] v;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: f = FUNC_NONE;
        1, 2, 3, 4, 5, 6: f = FUNC_LOAD;
        7, 8, 9, 10, 11, 12: f = FUNC_ADD;
        default: f = FUNC_QUERY;
      endcase
      lim = ($urandom_range(0, 9) == 0) ? MAX_EL - 1 : elem_count - 1;
      a = $urandom_range(0, lim);
      b = $urandom_range(0, lim);
      if (a > b && $urandom_range(0, 7) != 0) begin
        lim = a; a = b; b = lim;
      end
      v = {$urandom, $urandom};
      if ($urandom_range(0, 2) == 0) v = $signed(v[15:0]);
      send_item(f, a[IDX_W-1:0], b[IDX_W-1:0], v, 1'b0, '0);
    end
  endtask

  // Result side: random stall per transfer, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_long = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (sum_fifo.size() == 0) begin
        $display("unexpected result transfer: range_sum %h", range_sum_o);
        error_cnt++;
      end else begin
        logic [63:0] want;
        want = sum_fifo.pop_front();
        if (range_sum_o !== want) report_mismatch(range_sum_o, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    logic [CNT_W-1:0] counts [$];
    clear_array(RST_COUNT);
    rows = '{
      '{FUNC_QUERY, 10'd0,    10'd1023, 64'h0, 1'b1, 64'h0},
      '{FUNC_LOAD,  10'd0,    10'd0,    64'h7fff_ffff_ffff_ffff, 1'b1, 64'h0},
      '{FUNC_LOAD,  10'd1023, 10'd0,    64'h8000_0000_0000_0000, 1'b1, 64'h0},
      '{FUNC_QUERY, 10'd0,    10'd1023, 64'h0, 1'b1, 64'hffff_ffff_ffff_ffff},
      '{FUNC_QUERY, 10'd5,    10'd4,    64'h0, 1'b1, 64'h0},
      '{FUNC_NONE,  10'd0,    10'd1023, 64'hffff_ffff_ffff_ffff, 1'b1, 64'h0},
      '{FUNC_ADD,   10'd0,    10'd1023, 64'h1, 1'b1, 64'h0},
      '{FUNC_QUERY, 10'd5,    10'd5,    64'h0, 1'b1, 64'h1},
      '{FUNC_ADD,   10'd9,    10'd3,    64'h55, 1'b1, 64'h0},
      '{FUNC_ADD,   10'd100,  10'd355,  64'hffff_ffff_ffff_fffd, 1'b0, 64'h0},
      '{FUNC_ADD,   10'd200,  10'd200,  64'h1234_5678_9abc_def0, 1'b0, 64'h0},
      '{FUNC_LOAD,  10'd150,  10'd0,    64'h3ff, 1'b0, 64'h0},
      '{FUNC_QUERY, 10'd99,   10'd201,  64'h0, 1'b0, 64'h0},
      '{FUNC_QUERY, 10'd1023, 10'd1023, 64'h0, 1'b0, 64'h0},
      '{FUNC_QUERY, 10'd0,    10'd0,    64'h0, 1'b0, 64'h0},
      '{FUNC_QUERY, 10'd0,    10'd1023, 64'h0, 1'b0, 64'h0}
    };
    // Writes cover both clamps and every data bit at both levels.
    counts = '{11'd1, 11'd2047, 11'd0, 11'd37, 11'd1024, 11'd513, 11'd3, 11'd1024};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_item(rows[i].func, rows[i].first, rows[i].last, rows[i].value,
                                rows[i].typed, rows[i].sum);
    random_items(80);
    hold_long = 1'b1;
    random_items(60);
    foreach (counts[i]) begin
      wait_idle();
      write_count(counts[i]);
      // After a write to a small count, directed items check that out-of-range indices are ignored or clamped.
      if (i == 3) begin
        send_item(FUNC_LOAD, 10'd37, 10'd0, 64'h5, 1'b1, 64'h0);
        send_item(FUNC_QUERY, 10'd40, 10'd1023, 64'h0, 1'b1, 64'h0);
        send_item(FUNC_ADD, 10'd30, 10'd1023, 64'h2, 1'b1, 64'h0);
        send_item(FUNC_QUERY, 10'd0, 10'd1023, 64'h0, 1'b1, 64'd14);
      end
      random_items((RANDOM_ITEMS - 140) / 8);
    end
    wait_idle();
    if (error_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rast_pkg.sv
rtl/core/rast_ram.sv
rtl/core/rast_mul.sv
rtl/core/range_add_range_sum_tree_top.sv
verif/tb_range_add_range_sum_tree_top.sv
